// ----- design/gsfr_pkg.sv -----
// Shared types, constants and helpers of the gas sensor frame receiver.
package gsfr_pkg;

  localparam int MAX_SLOTS    = 5;
  localparam int FRAME_LENGTH = 9;
  localparam int FRAME_LAST   = FRAME_LENGTH - 1;

  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [2:0] MAX_CHANNELS = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] FS_NONE    = 2'd0;
  localparam logic [1:0] FS_MATCH   = 2'd1;
  localparam logic [1:0] FS_BAD_SUM = 2'd2;
  localparam logic [1:0] FS_UNKNOWN = 2'd3;

  localparam logic [2:0] REG_SLOT0   = 3'd0;
  localparam logic [2:0] REG_DWELL   = 3'd5;
  localparam logic [2:0] REG_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_CHANS   = 3'd7;

  localparam logic [2:0] FB_START  = 3'd0;
  localparam logic [2:0] FB_CODE   = 3'd1;
  localparam logic [2:0] FB_UNIT   = 3'd2;
  localparam logic [2:0] FB_VAL_HI = 3'd4;
  localparam logic [2:0] FB_VAL_LO = 3'd5;

  typedef struct packed {
    logic [15:0] dwell_limit;
    logic [15:0] timeout;
    logic [2:0]  chan_count;
  } cfg_t;

  typedef struct packed {
    logic       we;
    logic [2:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [2:0] raddr;
  } fb_req_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [7:0]  unit;
    logic [15:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  waddr;
    slot_entry_t wdata;
    logic        re;
    logic [2:0]  raddr;
  } slot_req_t;

  function automatic logic [1:0] next_channel(input logic [1:0] cur, input logic [2:0] cnt);
    logic [2:0] eff;
    logic [2:0] n;
    eff = cnt;
    if (cnt == 3'd0) begin
      eff = 3'd1;
    end else if (cnt > MAX_CHANNELS) begin
      eff = MAX_CHANNELS;
    end
    n = {1'b0, cur} + 3'd1;
    for (int i = 0; i < 4; i++) begin
      if (n >= eff) begin
        n = n - eff;
      end
    end
    return n[1:0];
  endfunction

endpackage

// ----- design/gsfr_cfg.sv -----
// Configuration register file with APB-style access.
module gsfr_cfg #(
  parameter int SLOTS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output gsfr_pkg::cfg_t         cfg,
  output logic [SLOTS-1:0][7:0]  codes
);
  import gsfr_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_limit <= 16'd2000;
      cfg.timeout     <= 16'd5000;
      cfg.chan_count  <= 3'd4;
      for (int i = 0; i < SLOTS; i++) begin
        codes[i] <= 8'(i);
      end
    end else if (wr) begin
      unique case (idx)
        REG_DWELL:   cfg.dwell_limit <= pwdata[15:0];
        REG_TIMEOUT: cfg.timeout     <= pwdata[15:0];
        REG_CHANS:   cfg.chan_count  <= pwdata[2:0];
        default: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (idx == REG_SLOT0 + 3'(i)) begin
              codes[i] <= pwdata[7:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DWELL:   prdata[15:0] = cfg.dwell_limit;
      REG_TIMEOUT: prdata[15:0] = cfg.timeout;
      REG_CHANS:   prdata[2:0]  = cfg.chan_count;
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (idx == REG_SLOT0 + 3'(i)) begin
            prdata[7:0] = codes[i];
          end
        end
      end
    endcase
  end

endmodule

// ----- design/gsfr_frame_buf.sv -----
// Frame byte memory: one write port, one registered read port.
module gsfr_frame_buf (
  input  logic              clk,
  input  gsfr_pkg::fb_req_t req,
  output logic [7:0]        rd_data
);
  import gsfr_pkg::*;

  logic [7:0] mem [8];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ----- design/gsfr_slot_store.sv -----
// Slot reading memory with per-entry valid bits; unwritten entries read as zero.
module gsfr_slot_store #(
  parameter int SLOTS = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gsfr_pkg::slot_req_t     req,
  output gsfr_pkg::slot_entry_t   rd_data
);
  import gsfr_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slot_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] valid;
  slot_entry_t      rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.re) begin
        rd_vld <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (req.raddr == 3'(i)) begin
            rd_vld <= valid[i];
          end
        end
      end
      if (req.we) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (req.waddr == 3'(i)) begin
            valid[i] <= 1'b1;
          end
        end
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- design/gas_sensor_frame_receiver_mux_unit.sv -----
// Top level: frame parser, slot update and mux dwell sequencer.
//
//  channel  | signals                                  | moves
//  ---------+------------------------------------------+------------------------------
//  in       | in_valid, in_ready, cmd, rx_byte, ...     | one byte or tick word
//  out      | out_valid, out_ready, frame_status, ...   | one result word per input
//  cfg      | psel, penable, pwrite, paddr, pwdata, ... | register write / read
//
// A plain byte passes S_EXEC and S_DONE; a frame's last byte runs four frame
// memory reads, then the slot match and write; a tick ages the slot memory in
// S_AGE, one entry per cycle. One word is in work at a time; the next word is
// taken while the previous result waits in the output register.
// Reset is synchronous; slot entries read as zero until first written.
// A stalled output holds the sequencer in its final state.
module gas_sensor_frame_receiver_mux_unit #(
  parameter int SENSOR_SLOTS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [2:0]  matched_slot,
  output logic [7:0]  frame_gas_code,
  output logic [15:0] frame_value,
  output logic [7:0]  frame_unit,
  output logic [1:0]  mux_select,
  output logic        channel_switched,
  output logic [4:0]  connected_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gsfr_pkg::*;

  localparam int AW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FRD    = 3'd2;
  localparam logic [2:0] S_FMATCH = 3'd3;
  localparam logic [2:0] S_AGE    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  cfg_t                        cfg;
  logic [SENSOR_SLOTS-1:0][7:0] codes;
  fb_req_t                     fb_req;
  logic [7:0]                  fb_rd_data;
  slot_req_t                   slot_req;
  slot_entry_t                 slot_rd_data;

  logic [2:0]              state;
  logic                    cmd_q;
  logic [7:0]              byte_q;
  logic [15:0]             el_q;
  logic                    collecting;
  logic [3:0]              byte_count;
  logic [7:0]              fsum;
  logic [1:0]              fstep;
  logic [AW-1:0]           age_idx;
  logic [1:0]              channel;
  logic [16:0]             dwell;
  logic                    pending;
  logic [SENSOR_SLOTS-1:0] conn;

  logic [1:0]  res_status;
  logic [2:0]  res_slot;
  logic [7:0]  res_code;
  logic [15:0] res_value;
  logic [7:0]  res_unit;
  logic        res_sw;

  logic        sum_ok;
  logic        hit;
  logic [2:0]  hit_idx;
  logic        expired;
  slot_entry_t aged;
  logic [16:0] dwell_sum;
  logic        do_switch;
  logic [4:0]  mask_w;

  gsfr_cfg #(.SLOTS(SENSOR_SLOTS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .codes   (codes)
  );

  gsfr_frame_buf u_frame_buf (
    .clk     (clk),
    .req     (fb_req),
    .rd_data (fb_rd_data)
  );

  gsfr_slot_store #(.SLOTS(SENSOR_SLOTS)) u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .req     (slot_req),
    .rd_data (slot_rd_data)
  );

  assign in_ready = (state == S_IDLE);

  assign sum_ok    = (8'(8'd0 - fsum) == byte_q);
  assign dwell_sum = dwell + {1'b0, el_q};
  assign do_switch = pending || (dwell_sum >= {1'b0, cfg.dwell_limit});
  assign expired   = (slot_rd_data.timeout <= el_q);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SENSOR_SLOTS - 1; i >= 0; i--) begin
      if (codes[i] == res_code) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    aged         = slot_rd_data;
    aged.timeout = expired ? 16'd0 : 16'(slot_rd_data.timeout - el_q);
  end

  always_comb begin
    mask_w = '0;
    mask_w[SENSOR_SLOTS-1:0] = conn;
  end

  always_comb begin
    fb_req   = '0;
    slot_req = '0;
    unique case (state)
      S_EXEC: begin
        if (cmd_q == CMD_BYTE) begin
          if (!collecting) begin
            fb_req.we    = (byte_q == START_BYTE);
            fb_req.waddr = FB_START;
            fb_req.wdata = byte_q;
          end else if (byte_count < 4'(FRAME_LAST)) begin
            fb_req.we    = 1'b1;
            fb_req.waddr = byte_count[2:0];
            fb_req.wdata = byte_q;
          end else begin
            fb_req.re    = 1'b1;
            fb_req.raddr = FB_CODE;
          end
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = '0;
        end
      end
      S_FRD: begin
        unique case (fstep)
          2'd0: begin
            fb_req.re    = 1'b1;
            fb_req.raddr = FB_UNIT;
          end
          2'd1: begin
            fb_req.re    = 1'b1;
            fb_req.raddr = FB_VAL_HI;
          end
          2'd2: begin
            fb_req.re    = 1'b1;
            fb_req.raddr = FB_VAL_LO;
          end
          default: fb_req.re = 1'b0;
        endcase
      end
      S_FMATCH: begin
        slot_req.we            = sum_ok && hit;
        slot_req.waddr         = hit_idx;
        slot_req.wdata.timeout = cfg.timeout;
        slot_req.wdata.unit    = res_unit;
        slot_req.wdata.value   = res_value;
      end
      S_AGE: begin
        slot_req.we    = 1'b1;
        slot_req.waddr = 3'(age_idx);
        slot_req.wdata = aged;
        if (age_idx != AW'(SENSOR_SLOTS - 1)) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = 3'(age_idx) + 3'd1;
        end
      end
      default: begin
        fb_req   = '0;
        slot_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      collecting <= 1'b0;
      byte_count <= '0;
      channel    <= '0;
      dwell      <= '0;
      pending    <= 1'b0;
      conn       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            byte_q     <= rx_byte;
            el_q       <= elapsed_ms;
            res_status <= FS_NONE;
            res_slot   <= '0;
            res_code   <= '0;
            res_value  <= '0;
            res_unit   <= '0;
            res_sw     <= 1'b0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_q == CMD_BYTE) begin
            if (!collecting) begin
              if (byte_q == START_BYTE) begin
                collecting <= 1'b1;
                byte_count <= 4'd1;
                fsum       <= '0;
              end
              state <= S_DONE;
            end else if (byte_count < 4'(FRAME_LAST)) begin
              byte_count <= byte_count + 4'd1;
              fsum       <= fsum + byte_q;
              state      <= S_DONE;
            end else begin
              collecting <= 1'b0;
              byte_count <= '0;
              fstep      <= '0;
              state      <= S_FRD;
            end
          end else begin
            if (do_switch) begin
              dwell      <= '0;
              channel    <= next_channel(channel, cfg.chan_count);
              collecting <= 1'b0;
              byte_count <= '0;
              pending    <= 1'b0;
              res_sw     <= 1'b1;
            end else begin
              dwell <= dwell_sum;
            end
            age_idx <= '0;
            state   <= S_AGE;
          end
        end
        S_FRD: begin
          unique case (fstep)
            2'd0: res_code          <= fb_rd_data;
            2'd1: res_unit          <= fb_rd_data;
            2'd2: res_value[15:8]   <= fb_rd_data;
            default: res_value[7:0] <= fb_rd_data;
          endcase
          fstep <= fstep + 2'd1;
          if (fstep == 2'd3) begin
            state <= S_FMATCH;
          end
        end
        S_FMATCH: begin
          if (!sum_ok) begin
            res_status <= FS_BAD_SUM;
          end else if (!hit) begin
            res_status <= FS_UNKNOWN;
          end else begin
            res_status <= FS_MATCH;
            res_slot   <= hit_idx;
            pending    <= 1'b1;
            for (int i = 0; i < SENSOR_SLOTS; i++) begin
              if (hit_idx == 3'(i)) begin
                conn[i] <= 1'b1;
              end
            end
          end
          state <= S_DONE;
        end
        S_AGE: begin
          if (expired) begin
            for (int i = 0; i < SENSOR_SLOTS; i++) begin
              if (age_idx == AW'(i)) begin
                conn[i] <= 1'b0;
              end
            end
          end
          if (age_idx == AW'(SENSOR_SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            age_idx <= age_idx + AW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      frame_status     <= res_status;
      matched_slot     <= res_slot;
      frame_gas_code   <= res_code;
      frame_value      <= res_value;
      frame_unit       <= res_unit;
      mux_select       <= channel;
      channel_switched <= res_sw;
      connected_mask   <= mask_w;
    end
  end

  a_slot_only_on_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status != FS_MATCH) |-> (matched_slot == 3'd0))
    else $error("matched_slot set without a matched frame");

  a_switch_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_switched |-> (frame_status == FS_NONE))
    else $error("channel switch reported with a frame result");

  a_match_is_connected: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status == FS_MATCH) |-> connected_mask[matched_slot])
    else $error("matched slot not marked connected");

  a_age_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) |-> (age_idx <= AW'(SENSOR_SLOTS - 1)))
    else $error("aging index beyond slot count");

  a_done_follows_age: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) && (age_idx == AW'(SENSOR_SLOTS - 1)) |=> (state == S_DONE))
    else $error("aging pass did not end");

endmodule
